/* rtl/core/ehp_pkg.sv */
package ehp_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] CFG_SINGLE_TAG = 2'd0;
  localparam logic [1:0] CFG_DOUBLE_TAG = 2'd1;
  localparam logic [1:0] CFG_IPV4_TYPE  = 2'd2;
  localparam logic [1:0] CFG_IPV6_TYPE  = 2'd3;

  localparam logic [15:0] RST_SINGLE_TAG = 16'h8100;
  localparam logic [15:0] RST_DOUBLE_TAG = 16'h9100;
  localparam logic [15:0] RST_IPV4_TYPE  = 16'h0800;
  localparam logic [15:0] RST_IPV6_TYPE  = 16'h86DD;

  // parse status codes
  localparam logic [2:0] ST_NONE = 3'd0;
  localparam logic [2:0] ST_L2   = 3'd1;
  localparam logic [2:0] ST_L3   = 3'd2;
  localparam logic [2:0] ST_TCP  = 3'd3;
  localparam logic [2:0] ST_UDP  = 3'd4;
  localparam logic [2:0] ST_ICMP = 3'd5;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  // frame byte positions
  localparam int unsigned POS_SMAC  = 6;
  localparam int unsigned POS_TYPE0 = 12;
  localparam int unsigned POS_TAG0  = 14;
  localparam int unsigned POS_TYPE1 = 16;
  localparam int unsigned POS_TAG1  = 18;
  localparam int unsigned POS_TYPE2 = 20;
  localparam int unsigned POS_END   = 22;

  localparam logic [4:0] L3_UNTAGGED = 5'd14;
  localparam logic [4:0] L3_ONE_TAG  = 5'd18;
  localparam logic [4:0] L3_TWO_TAGS = 5'd22;

  localparam logic [11:0] VID_MASK  = 12'hFFF;
  localparam int unsigned IPV4_MIN  = 20;
  localparam int unsigned IPV6_LEN  = 40;
  localparam int unsigned SHORT_L4  = 8;
  localparam int unsigned TCP_MIN   = 20;
  localparam int unsigned L4_KEEP   = 13;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       is_ethernet;
  } in_t;

  typedef struct packed {
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [1:0]  vlan_tags;
    logic [23:0] vlan_ids;
    logic [15:0] final_ethertype;
    logic [63:0] ip_source_high;
    logic [63:0] ip_source_low;
    logic [63:0] ip_dest_high;
    logic [63:0] ip_dest_low;
    logic [7:0]  ip_protocol;
    logic [31:0] l4_ports;
    logic [2:0]  parse_status;
  } out_t;

  typedef struct packed {
    logic [15:0] single_tag;
    logic [15:0] double_tag;
    logic [15:0] ipv4_type;
    logic [15:0] ipv6_type;
  } cfg_t;

  // frame state after the current byte has been captured
  typedef struct packed {
    logic              fie;
    logic [47:0]       dmac;
    logic [47:0]       smac;
    logic [15:0]       type0;
    logic [15:0]       type1;
    logic [15:0]       type2;
    logic [15:0]       tag0;
    logic [15:0]       tag1;
    logic [4:0]        l3;
    logic [6:0]        l4;
    logic [39:0][7:0]  ip;
    logic [12:0][7:0]  l4b;
  } frame_view_t;

endpackage

/* rtl/core/ehp_capture.sv */
module ehp_capture
  import ehp_pkg::*;
#(
  parameter int LENGTH_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   go,
  input  in_t                    item,
  input  cfg_t                   cfg,
  output frame_view_t            view,
  output logic [LENGTH_BITS-1:0] count
);

  localparam logic [LENGTH_BITS-1:0] CNT_MAX = '1;

  logic [LENGTH_BITS-1:0] idx_r;
  logic                   fie_r;
  logic [47:0]            dmac_r, smac_r;
  logic [15:0]            type0_r, type1_r, type2_r, tag0_r, tag1_r;
  logic [4:0]             l3_r;
  logic [6:0]             l4_r;
  logic [39:0][7:0]       ip_r;
  logic [12:0][7:0]       l4b_r;

  logic [7:0]             b;
  logic [LENGTH_BITS-1:0] i, l3_ext, l4_ext, ip_off, l4_off;
  logic [15:0]            ftype;

  always_comb begin
    b = item.data_byte;
    i = idx_r;
    view.fie   = (i == '0) ? item.is_ethernet : fie_r;
    view.dmac  = dmac_r;
    view.smac  = smac_r;
    view.type0 = type0_r;
    view.type1 = type1_r;
    view.type2 = type2_r;
    view.tag0  = tag0_r;
    view.tag1  = tag1_r;
    view.l3    = l3_r;
    view.l4    = l4_r;
    view.ip    = ip_r;
    view.l4b   = l4b_r;

    priority if (i < LENGTH_BITS'(POS_SMAC))  view.dmac  = {dmac_r[39:0], b};
    else if (i < LENGTH_BITS'(POS_TYPE0)) view.smac  = {smac_r[39:0], b};
    else if (i < LENGTH_BITS'(POS_TAG0))  view.type0 = {type0_r[7:0], b};
    else if (i < LENGTH_BITS'(POS_TYPE1)) view.tag0  = {tag0_r[7:0], b};
    else if (i < LENGTH_BITS'(POS_TAG1))  view.type1 = {type1_r[7:0], b};
    else if (i < LENGTH_BITS'(POS_TYPE2)) view.tag1  = {tag1_r[7:0], b};
    else if (i < LENGTH_BITS'(POS_END))   view.type2 = {type2_r[7:0], b};
    else begin
    end

    // pick the l3 start once the outer type is complete
    if (i == LENGTH_BITS'(POS_TAG0 - 1)) begin
      priority if (view.type0 == cfg.single_tag) view.l3 = L3_ONE_TAG;
      else if (view.type0 == cfg.double_tag)     view.l3 = L3_TWO_TAGS;
      else                                       view.l3 = L3_UNTAGGED;
    end
    if (i == LENGTH_BITS'(POS_TAG1 - 1) && view.type0 == cfg.single_tag &&
        view.type1 == cfg.single_tag)
      view.l3 = L3_TWO_TAGS;

    priority if (view.l3 == L3_ONE_TAG) ftype = view.type1;
    else if (view.l3 == L3_TWO_TAGS)    ftype = view.type2;
    else                                ftype = view.type0;

    l3_ext = LENGTH_BITS'(view.l3);
    if (i == l3_ext) begin
      if (ftype == cfg.ipv4_type)
        view.l4 = {2'b00, view.l3} + {1'b0, b[3:0], 2'b00};
      else
        view.l4 = {2'b00, view.l3} + 7'(IPV6_LEN);
    end
    l4_ext = LENGTH_BITS'(view.l4);

    ip_off = i - l3_ext;
    l4_off = i - l4_ext;
    if (i >= l3_ext && ip_off < LENGTH_BITS'(IPV6_LEN))
      view.ip[ip_off[5:0]] = b;
    if (i >= l3_ext && i >= l4_ext && l4_off < LENGTH_BITS'(L4_KEEP))
      view.l4b[l4_off[3:0]] = b;

    count = (i == CNT_MAX) ? i : i + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      fie_r   <= 1'b0;
      dmac_r  <= '0;
      smac_r  <= '0;
      type0_r <= '0;
      type1_r <= '0;
      type2_r <= '0;
      tag0_r  <= '0;
      tag1_r  <= '0;
      l3_r    <= L3_UNTAGGED;
      l4_r    <= '0;
    end else if (go) begin
      fie_r <= view.fie;
      if (item.last_byte) begin
        idx_r   <= '0;
        dmac_r  <= '0;
        smac_r  <= '0;
        type0_r <= '0;
        type1_r <= '0;
        type2_r <= '0;
        tag0_r  <= '0;
        tag1_r  <= '0;
        l3_r    <= L3_UNTAGGED;
        l4_r    <= '0;
      end else begin
        idx_r   <= count;
        dmac_r  <= view.dmac;
        smac_r  <= view.smac;
        type0_r <= view.type0;
        type1_r <= view.type1;
        type2_r <= view.type2;
        tag0_r  <= view.tag0;
        tag1_r  <= view.tag1;
        l3_r    <= view.l3;
        l4_r    <= view.l4;
      end
    end
  end

  // header byte stores, only read where the current frame wrote them
  always_ff @(posedge clk) begin
    if (go) begin
      ip_r  <= view.ip;
      l4b_r <= view.l4b;
    end
  end

endmodule

/* rtl/core/ehp_record.sv */
module ehp_record
  import ehp_pkg::*;
#(
  parameter int LENGTH_BITS = 16
) (
  input  frame_view_t            view,
  input  logic [LENGTH_BITS-1:0] count,
  input  cfg_t                   cfg,
  output out_t                   rec
);

  // length from off to count reaches thr; a count below off wraps high
  function automatic logic len_ge(input logic [LENGTH_BITS-1:0] n,
                                  input logic [LENGTH_BITS-1:0] off,
                                  input logic [7:0] thr);
    logic [LENGTH_BITS-1:0] d;
    begin
      d = n - off;
      len_ge = (n < off) || (d >= LENGTH_BITS'(thr));
    end
  endfunction

  logic        l2_ok, l3_ok, l4_ok;
  logic [15:0] etype;
  logic [1:0]  tags;
  logic [23:0] vids;
  logic [7:0]  proto;
  logic [2:0]  status;
  logic [LENGTH_BITS-1:0] l3_ext, l4_ext;
  logic [63:0] sh, sl, dh, dl;

  always_comb begin
    l3_ext = LENGTH_BITS'(view.l3);
    l4_ext = LENGTH_BITS'(view.l4);
    rec    = '0;
    etype  = view.type0;
    tags   = 2'd0;
    vids   = '0;
    l2_ok  = view.fie && (count >= LENGTH_BITS'(POS_TAG0));
    if (view.type0 == cfg.single_tag) begin
      if (count < LENGTH_BITS'(POS_TAG1)) l2_ok = 1'b0;
      vids  = {view.tag0[11:0] & VID_MASK, 12'h000};
      tags  = 2'd1;
      etype = view.type1;
      if (view.type1 == cfg.single_tag) begin
        if (count < LENGTH_BITS'(POS_END)) l2_ok = 1'b0;
        vids[11:0] = view.tag1[11:0] & VID_MASK;
        tags  = 2'd2;
        etype = view.type2;
      end
    end else if (view.type0 == cfg.double_tag) begin
      if (count < LENGTH_BITS'(POS_END)) l2_ok = 1'b0;
      vids  = {view.tag0[11:0] & VID_MASK, view.tag1[11:0] & VID_MASK};
      tags  = 2'd2;
      etype = view.type2;
    end

    sh = '0;
    sl = '0;
    dh = '0;
    dl = '0;
    proto = '0;
    l3_ok = 1'b0;
    if (etype == cfg.ipv4_type) begin
      l3_ok = len_ge(count, l3_ext, 8'(IPV4_MIN)) &&
              len_ge(count, l3_ext, {2'b00, view.ip[0][3:0], 2'b00});
      sl    = {32'h0000FFFF, view.ip[12], view.ip[13], view.ip[14], view.ip[15]};
      dl    = {32'h0000FFFF, view.ip[16], view.ip[17], view.ip[18], view.ip[19]};
      proto = view.ip[9];
    end else if (etype == cfg.ipv6_type) begin
      l3_ok = len_ge(count, l3_ext, 8'(IPV6_LEN));
      sh = {view.ip[8], view.ip[9], view.ip[10], view.ip[11],
            view.ip[12], view.ip[13], view.ip[14], view.ip[15]};
      sl = {view.ip[16], view.ip[17], view.ip[18], view.ip[19],
            view.ip[20], view.ip[21], view.ip[22], view.ip[23]};
      dh = {view.ip[24], view.ip[25], view.ip[26], view.ip[27],
            view.ip[28], view.ip[29], view.ip[30], view.ip[31]};
      dl = {view.ip[32], view.ip[33], view.ip[34], view.ip[35],
            view.ip[36], view.ip[37], view.ip[38], view.ip[39]};
      proto = view.ip[6];
    end

    status = ST_L3;
    l4_ok  = 1'b0;
    priority if (proto == PROTO_TCP) begin
      l4_ok = len_ge(count, l4_ext, 8'(TCP_MIN)) &&
              len_ge(count, l4_ext, {2'b00, view.l4b[12][7:4], 2'b00});
      if (l4_ok) status = ST_TCP;
    end else if (proto == PROTO_UDP) begin
      if (len_ge(count, l4_ext, 8'(SHORT_L4))) status = ST_UDP;
    end else if (proto == PROTO_ICMP) begin
      if (len_ge(count, l4_ext, 8'(SHORT_L4))) status = ST_ICMP;
    end else begin
    end

    if (l2_ok) begin
      rec.dest_mac        = view.dmac;
      rec.source_mac      = view.smac;
      rec.vlan_tags       = tags;
      rec.vlan_ids        = vids;
      rec.final_ethertype = etype;
      rec.parse_status    = ST_L2;
      if (l3_ok) begin
        rec.ip_source_high = sh;
        rec.ip_source_low  = sl;
        rec.ip_dest_high   = dh;
        rec.ip_dest_low    = dl;
        rec.ip_protocol    = proto;
        rec.parse_status   = status;
        if (status == ST_TCP || status == ST_UDP)
          rec.l4_ports = {view.l4b[0], view.l4b[1], view.l4b[2], view.l4b[3]};
        else if (status == ST_ICMP)
          rec.l4_ports = {8'h00, view.l4b[0], 8'h00, view.l4b[1]};
      end
    end
  end

endmodule

/* rtl/core/ethernet_ip_l4_header_parser_core.sv */
// ethernet / vlan / ipv4 / ipv6 / tcp / udp / icmp header parser
// input channel: one frame byte per request (in_data), with a last-byte
//   mark and the link-type flag, which counts only on the first byte
// result channel: one header record per frame, sent after the last byte
// config port: cfg_we writes cfg_wdata into register cfg_idx at once
//   (0 single tag type, 1 double tag type, 2 ipv4 type, 3 ipv6 type)
// pipeline: a request enters the input register; when it moves on, it is
//   captured into the frame state and, on the last byte, the record is
//   built from that state into the output register, which drives out_valid
// throughput: one byte per cycle unless stalled, set by one capture stage
// stall: while the output register holds an untaken record, non-last
//   bytes keep flowing; a last byte waits in the input register
// reset: synchronous, active low; clears the frame state and restores the
//   tag and ip type registers to their defaults; no clearing pass
module ethernet_ip_l4_header_parser_core
  import ehp_pkg::*;
#(
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_wdata
);

  cfg_t        cfg_r;
  in_t         in_data_r;
  logic        in_vld_r, in_vld_nxt;
  logic        out_vld_r, out_vld_nxt;
  out_t        out_data_r;
  logic        s1_go;
  frame_view_t view;
  out_t        rec;
  logic [LENGTH_BITS-1:0] count;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.single_tag <= RST_SINGLE_TAG;
      cfg_r.double_tag <= RST_DOUBLE_TAG;
      cfg_r.ipv4_type  <= RST_IPV4_TYPE;
      cfg_r.ipv6_type  <= RST_IPV6_TYPE;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_SINGLE_TAG: cfg_r.single_tag <= cfg_wdata;
        CFG_DOUBLE_TAG: cfg_r.double_tag <= cfg_wdata;
        CFG_IPV4_TYPE:  cfg_r.ipv4_type  <= cfg_wdata;
        CFG_IPV6_TYPE:  cfg_r.ipv6_type  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // a buffered byte moves on unless it ends a frame and the output is held
  assign s1_go    = in_vld_r && (!in_data_r.last_byte || !out_vld_r || out_ready);
  assign in_ready = !in_vld_r || s1_go;

  always_comb begin
    in_vld_nxt  = (in_valid && in_ready) || (in_vld_r && !s1_go);
    out_vld_nxt = (out_vld_r && !out_ready) || (s1_go && in_data_r.last_byte);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_data_r <= in_data;
    if (s1_go && in_data_r.last_byte) out_data_r <= rec;
  end

  ehp_capture #(.LENGTH_BITS(LENGTH_BITS)) u_capture (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (s1_go),
    .item  (in_data_r),
    .cfg   (cfg_r),
    .view  (view),
    .count (count)
  );

  ehp_record #(.LENGTH_BITS(LENGTH_BITS)) u_record (
    .view  (view),
    .count (count),
    .cfg   (cfg_r),
    .rec   (rec)
  );

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/core/ehp_checker.sv */
module ehp_checker
  import ehp_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.parse_status <= ST_ICMP)
    else $error("bad parse status");

  a_none_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.parse_status == ST_NONE |->
      out_data.dest_mac == '0 && out_data.vlan_tags == '0 &&
      out_data.final_ethertype == '0 && out_data.ip_protocol == '0)
    else $error("fields set without l2");

  a_l2_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.parse_status == ST_L2 || out_data.parse_status == ST_L3)
      |-> out_data.l4_ports == '0)
    else $error("l4 ports set without l4");

endmodule

bind ethernet_ip_l4_header_parser_core ehp_checker u_ehp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* sim/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import ehp_pkg::*;

  // clock, reset and ports
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = CFG_SINGLE_TAG;
  logic [15:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  ethernet_ip_l4_header_parser_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // l3 kinds used by the frame builder
  localparam int L3K_IPV4  = 0;
  localparam int L3K_IPV6  = 1;
  localparam int L3K_OTHER = 2;
  // tag layouts used by the frame builder
  localparam int TAGS_NONE    = 0;
  localparam int TAGS_SINGLE  = 1;
  localparam int TAGS_STACKED = 2;
  localparam int TAGS_DOUBLE  = 3;

  // ethertype registers as the parser currently sees them
  logic [15:0] single_tag_q = RST_SINGLE_TAG;
  logic [15:0] double_tag_q = RST_DOUBLE_TAG;
  logic [15:0] ipv4_type_q  = RST_IPV4_TYPE;
  logic [15:0] ipv6_type_q  = RST_IPV6_TYPE;

  // frame state tracked byte by byte
  logic [15:0] byte_cnt = '0;
  logic        frame_eth = 1'b0;
  logic [47:0] dmac_acc = '0;
  logic [47:0] smac_acc = '0;
  logic [15:0] type_acc [3];
  logic [15:0] tag_acc [2];
  logic [4:0]  l3_pos = L3_UNTAGGED;
  logic [6:0]  l4_pos = '0;
  logic [7:0]  ip_hdr [40];
  logic [7:0]  l4_hdr [13];

  out_t        header_q [$];
  int          errors = 0;
  int          records_seen = 0;
  int          frames_sent = 0;
  int          bytes_sent = 0;
  int          settings_used = 1;
  int          rx_hold = 0;
  bit          rx_idle_on = 1'b1;
  bit          tx_idle_on = 1'b1;
  bit          pressure_done = 1'b0;

  // typed-in expectation for directed rows
  bit          force_zero = 1'b0;
  int          force_status = -1;

  function automatic logic [15:0] ethertype_at_l3();
    if (l3_pos == L3_ONE_TAG) return type_acc[1];
    if (l3_pos == L3_TWO_TAGS) return type_acc[2];
    return type_acc[0];
  endfunction

  function automatic logic [63:0] ip_field(int start, int len);
    logic [63:0] v;
    v = '0;
    for (int k = 0; k < len; k++) v = {v[55:0], ip_hdr[(start + k) % IPV6_LEN]};
    return v;
  endfunction

  function automatic void reset_frame();
    byte_cnt = '0;
    dmac_acc = '0;
    smac_acc = '0;
    foreach (type_acc[k]) type_acc[k] = '0;
    foreach (tag_acc[k]) tag_acc[k] = '0;
    l3_pos = L3_UNTAGGED;
    l4_pos = '0;
  endfunction

  // header record for a frame of n bytes
  function automatic out_t header_record(int unsigned n);
    out_t r;
    logic [15:0] et;
    logic [7:0]  proto;
    int unsigned len;
    logic [2:0]  st;
    r = '0;
    if (!frame_eth || n < 14) return r;
    et = type_acc[0];
    if (et == single_tag_q) begin
      if (n < 18) return r;
      r.vlan_ids[23:12] = tag_acc[0][11:0] & VID_MASK;
      r.vlan_tags = 2'd1;
      et = type_acc[1];
      if (et == single_tag_q) begin
        if (n < 22) return '0;
        r.vlan_ids[11:0] = tag_acc[1][11:0] & VID_MASK;
        r.vlan_tags = 2'd2;
        et = type_acc[2];
      end
    end else if (et == double_tag_q) begin
      if (n < 22) return r;
      r.vlan_ids = {tag_acc[0][11:0], tag_acc[1][11:0]};
      r.vlan_tags = 2'd2;
      et = type_acc[2];
    end
    r.dest_mac = dmac_acc;
    r.source_mac = smac_acc;
    r.final_ethertype = et;
    r.parse_status = ST_L2;
    len = n - l3_pos;
    if (et == ipv4_type_q) begin
      if (len < IPV4_MIN || len < ip_hdr[0][3:0] * 4) return r;
      r.ip_source_low = {32'h0000ffff, 32'(ip_field(12, 4))};
      r.ip_dest_low = {32'h0000ffff, 32'(ip_field(16, 4))};
      proto = ip_hdr[9];
    end else if (et == ipv6_type_q) begin
      if (len < IPV6_LEN) return r;
      r.ip_source_high = ip_field(8, 8);
      r.ip_source_low = ip_field(16, 8);
      r.ip_dest_high = ip_field(24, 8);
      r.ip_dest_low = ip_field(32, 8);
      proto = ip_hdr[6];
    end else begin
      return r;
    end
    r.ip_protocol = proto;
    len = n - l4_pos;
    st = ST_L3;
    if (proto == PROTO_TCP) begin
      if (len >= TCP_MIN && len >= l4_hdr[12][7:4] * 4) st = ST_TCP;
    end else if (proto == PROTO_UDP) begin
      if (len >= SHORT_L4) st = ST_UDP;
    end else if (proto == PROTO_ICMP) begin
      if (len >= SHORT_L4) st = ST_ICMP;
    end
    if (st == ST_TCP || st == ST_UDP)
      r.l4_ports = {l4_hdr[0], l4_hdr[1], l4_hdr[2], l4_hdr[3]};
    else if (st == ST_ICMP)
      r.l4_ports = {8'h00, l4_hdr[0], 8'h00, l4_hdr[1]};
    r.parse_status = st;
    return r;
  endfunction

  // feed one accepted request to the tracked frame state
  function automatic bit absorb_byte(in_t req, output out_t rec);
    int unsigned i;
    logic [7:0] b;
    i = byte_cnt;
    b = req.data_byte;
    rec = '0;
    if (i == 0) frame_eth = req.is_ethernet;
    if (i < POS_SMAC) dmac_acc = {dmac_acc[39:0], b};
    else if (i < POS_TYPE0) smac_acc = {smac_acc[39:0], b};
    else if (i < POS_TAG0) type_acc[0] = {type_acc[0][7:0], b};
    else if (i < POS_TYPE1) tag_acc[0] = {tag_acc[0][7:0], b};
    else if (i < POS_TAG1) type_acc[1] = {type_acc[1][7:0], b};
    else if (i < POS_TYPE2) tag_acc[1] = {tag_acc[1][7:0], b};
    else if (i < POS_END) type_acc[2] = {type_acc[2][7:0], b};
    if (i == 13) begin
      if (type_acc[0] == single_tag_q) l3_pos = L3_ONE_TAG;
      else if (type_acc[0] == double_tag_q) l3_pos = L3_TWO_TAGS;
      else l3_pos = L3_UNTAGGED;
    end
    if (i == 17 && type_acc[0] == single_tag_q && type_acc[1] == single_tag_q)
      l3_pos = L3_TWO_TAGS;
    if (i == l3_pos) begin
      if (ethertype_at_l3() == ipv4_type_q) l4_pos = 7'(l3_pos + b[3:0] * 4);
      else l4_pos = 7'(l3_pos + IPV6_LEN);
    end
    if (i >= l3_pos && i - l3_pos < IPV6_LEN) ip_hdr[i - l3_pos] = b;
    if (i >= l3_pos && i >= l4_pos && i - l4_pos < L4_KEEP) l4_hdr[i - l4_pos] = b;
    if (byte_cnt != 16'hFFFF) byte_cnt++;
    if (!req.last_byte) return 1'b0;
    rec = header_record(byte_cnt);
    reset_frame();
    return 1'b1;
  endfunction

  task automatic check_field(string nm, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch: expected %h actual %h", $time, nm, e, a);
      errors++;
    end
  endtask

  // request and record monitor, sampled at the rising edge
  always @(posedge clk) begin
    out_t rec;
    out_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (absorb_byte(in_data, rec)) begin
          if (force_zero) rec = '0;
          else if (force_status >= 0) rec.parse_status = force_status[2:0];
          header_q.push_back(rec);
        end
      end
      if (out_valid && out_ready) begin
        records_seen++;
        rx_hold = rx_idle_on ? $urandom_range(0, 4) : 0;
        if (header_q.size() == 0) begin
          $display("%0t: unexpected record: expected none actual %h", $time, out_data);
          errors++;
        end else begin
          want = header_q.pop_front();
          check_field("dest_mac", want.dest_mac, out_data.dest_mac);
          check_field("source_mac", want.source_mac, out_data.source_mac);
          check_field("vlan_tags", want.vlan_tags, out_data.vlan_tags);
          check_field("vlan_ids", want.vlan_ids, out_data.vlan_ids);
          check_field("final_ethertype", want.final_ethertype, out_data.final_ethertype);
          check_field("ip_source_high", want.ip_source_high, out_data.ip_source_high);
          check_field("ip_source_low", want.ip_source_low, out_data.ip_source_low);
          check_field("ip_dest_high", want.ip_dest_high, out_data.ip_dest_high);
          check_field("ip_dest_low", want.ip_dest_low, out_data.ip_dest_low);
          check_field("ip_protocol", want.ip_protocol, out_data.ip_protocol);
          check_field("l4_ports", want.l4_ports, out_data.l4_ports);
          check_field("parse_status", want.parse_status, out_data.parse_status);
        end
      end
    end
  end

  // receiver: random stalls per record, plus one long hold-off so the
  // parser fills up and stalls its input
  initial begin
    forever begin
      @(negedge clk);
      if (rst_n && !pressure_done && records_seen >= 12) begin
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
        pressure_done = 1'b1;
      end else if (rx_hold > 0) begin
        out_ready <= 1'b0;
        rx_hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // one request; called and returns at a falling edge
  task automatic send_request(in_t req);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(logic [7:0] fr [], bit eth);
    in_t req;
    for (int k = 0; k < fr.size(); k++) begin
      req.data_byte = fr[k];
      req.last_byte = (k == fr.size() - 1);
      req.is_ethernet = (k == 0) ? eth : 1'($urandom);
      send_request(req);
    end
    frames_sent++;
  endtask

  // build a frame with the given layering; len 0 means just long enough
  task automatic build_frame(int tags, int l3k, logic [7:0] proto, int ihl, int doff,
                             int len, output logic [7:0] fr []);
    int l3;
    int l4;
    int need;
    int full;
    logic [15:0] et;
    l3 = (tags == TAGS_NONE) ? 14 : (tags == TAGS_SINGLE) ? 18 : 22;
    et = (l3k == L3K_IPV4) ? ipv4_type_q : (l3k == L3K_IPV6) ? ipv6_type_q : 16'($urandom);
    l4 = (l3k == L3K_IPV6) ? l3 + 40 : l3 + ihl * 4;
    need = (proto == PROTO_TCP) ? ((doff * 4 > 20) ? doff * 4 : 20) : 8;
    full = l4 + need;
    if (l3k == L3K_IPV4 && full < l3 + 20) full = l3 + 20;
    if (len == 0) len = full;
    fr = new[len];
    foreach (fr[k]) fr[k] = 8'($urandom);
    case (tags)
      TAGS_SINGLE: begin
        put16(fr, 12, single_tag_q);
        put16(fr, 16, et);
      end
      TAGS_STACKED: begin
        put16(fr, 12, single_tag_q);
        put16(fr, 16, single_tag_q);
        put16(fr, 20, et);
      end
      TAGS_DOUBLE: begin
        put16(fr, 12, double_tag_q);
        put16(fr, 20, et);
      end
      default: put16(fr, 12, et);
    endcase
    if (l3k == L3K_IPV4) begin
      if (l3 < len) fr[l3] = {4'h4, 4'(ihl)};
      if (l3 + 9 < len) fr[l3 + 9] = proto;
    end else if (l3k == L3K_IPV6) begin
      if (l3 + 6 < len) fr[l3 + 6] = proto;
    end
    if (proto == PROTO_TCP && l4 + 12 < len) fr[l4 + 12][7:4] = 4'(doff);
  endtask

  task automatic put16(ref logic [7:0] fr [], input int pos, input logic [15:0] v);
    if (pos < fr.size()) fr[pos] = v[15:8];
    if (pos + 1 < fr.size()) fr[pos + 1] = v[7:0];
  endtask

  // register write, only while the parser is idle
  task automatic write_reg(logic [1:0] idx, logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    case (idx)
      CFG_SINGLE_TAG: single_tag_q = v;
      CFG_DOUBLE_TAG: double_tag_q = v;
      CFG_IPV4_TYPE:  ipv4_type_q = v;
      default:        ipv6_type_q = v;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (header_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_setting(logic [15:0] s, logic [15:0] d, logic [15:0] v4,
                              logic [15:0] v6);
    wait_drained();
    write_reg(CFG_SINGLE_TAG, s);
    write_reg(CFG_DOUBLE_TAG, d);
    write_reg(CFG_IPV4_TYPE, v4);
    write_reg(CFG_IPV6_TYPE, v6);
    settings_used++;
  endtask

  // directed rows: layering, length, link flag and, where obvious, the record
  typedef struct {
    int tags;
    int l3k;
    int proto;
    int ihl;
    int doff;
    int len;
    bit eth;
    bit zero;
    int status;
  } frame_row_t;

  frame_row_t dir_rows [] = '{
    // not ethernet: empty record
    '{TAGS_NONE,    L3K_IPV4,  6,  5,  5,  0,     1'b0, 1'b1, -1},
    // one-byte frame and frames too short for l2
    '{TAGS_NONE,    L3K_IPV4,  6,  5,  5,  1,     1'b1, 1'b1, -1},
    '{TAGS_NONE,    L3K_IPV4,  6,  5,  5,  13,    1'b1, 1'b1, -1},
    '{TAGS_SINGLE,  L3K_IPV4,  6,  5,  5,  17,    1'b1, 1'b1, -1},
    '{TAGS_STACKED, L3K_IPV4,  6,  5,  5,  21,    1'b1, 1'b1, -1},
    '{TAGS_DOUBLE,  L3K_IPV4,  6,  5,  5,  21,    1'b1, 1'b1, -1},
    // l2 only: unknown type, short l3 headers
    '{TAGS_NONE,    L3K_OTHER, 6,  5,  5,  14,    1'b1, 1'b0, ST_L2},
    '{TAGS_SINGLE,  L3K_OTHER, 6,  5,  5,  18,    1'b1, 1'b0, ST_L2},
    '{TAGS_NONE,    L3K_IPV4,  6,  5,  5,  33,    1'b1, 1'b0, ST_L2},
    '{TAGS_NONE,    L3K_IPV4,  6,  15, 5,  73,    1'b1, 1'b0, ST_L2},
    '{TAGS_NONE,    L3K_IPV6,  6,  5,  5,  53,    1'b1, 1'b0, ST_L2},
    // full headers through each tag layout and protocol; an icmp one byte short
    '{TAGS_NONE,    L3K_IPV4,  6,  5,  5,  0,     1'b1, 1'b0, -1},
    '{TAGS_SINGLE,  L3K_IPV4,  17, 5,  5,  0,     1'b1, 1'b0, -1},
    '{TAGS_STACKED, L3K_IPV4,  17, 5,  5,  0,     1'b1, 1'b0, -1},
    '{TAGS_DOUBLE,  L3K_IPV6,  6,  5,  5,  0,     1'b1, 1'b0, -1},
    '{TAGS_NONE,    L3K_IPV6,  1,  5,  5,  0,     1'b1, 1'b0, -1},
    '{TAGS_NONE,    L3K_IPV4,  1,  5,  5,  41,    1'b1, 1'b0, -1},
    '{TAGS_NONE,    L3K_IPV4,  99, 15, 5,  74,    1'b1, 1'b0, -1},
    // udp one byte short, then exact
    '{TAGS_NONE,    L3K_IPV4,  17, 5,  5,  41,    1'b1, 1'b0, -1},
    '{TAGS_NONE,    L3K_IPV4,  17, 5,  5,  42,    1'b1, 1'b0, -1},
    // tcp with long data offset, short then full; ihl below five
    '{TAGS_NONE,    L3K_IPV4,  6,  5,  15, 54,    1'b1, 1'b0, -1},
    '{TAGS_NONE,    L3K_IPV4,  6,  5,  15, 0,     1'b1, 1'b0, -1},
    '{TAGS_NONE,    L3K_IPV4,  6,  0,  5,  0,     1'b1, 1'b0, -1},
    '{TAGS_SINGLE,  L3K_IPV6,  17, 5,  5,  0,     1'b1, 1'b0, -1}
  };

  task automatic random_frame();
    logic [7:0] fr [];
    int tags;
    int l3k;
    int pick;
    logic [7:0] proto;
    int ihl;
    int doff;
    int len;
    tags = $urandom_range(TAGS_NONE, TAGS_DOUBLE);
    pick = $urandom_range(0, 99);
    l3k = (pick < 45) ? L3K_IPV4 : (pick < 80) ? L3K_IPV6 : L3K_OTHER;
    pick = $urandom_range(0, 3);
    proto = (pick == 0) ? PROTO_TCP : (pick == 1) ? PROTO_UDP :
            (pick == 2) ? PROTO_ICMP : 8'($urandom);
    ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 5;
    doff = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 5;
    build_frame(tags, l3k, proto, ihl, doff, 0, fr);
    // a quarter of frames are cut short at a random point
    if ($urandom_range(0, 3) == 0) begin
      len = $urandom_range(1, fr.size());
      fr = new[len](fr);
    end
    tx_idle_on = ($urandom_range(0, 3) != 0);
    rx_idle_on = ($urandom_range(0, 3) != 0);
    send_frame(fr, $urandom_range(0, 19) != 0);
  endtask

  task automatic random_phase(int n_bytes, int n_frames);
    int b0;
    int f0;
    b0 = bytes_sent;
    f0 = frames_sent;
    while (bytes_sent - b0 < n_bytes || frames_sent - f0 < n_frames) random_frame();
  endtask

  initial begin
    logic [7:0] fr [];
    foreach (ip_hdr[k]) ip_hdr[k] = '0;
    foreach (l4_hdr[k]) l4_hdr[k] = '0;
    reset_frame();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // directed rows at reset settings
    foreach (dir_rows[r]) begin
      build_frame(dir_rows[r].tags, dir_rows[r].l3k, 8'(dir_rows[r].proto),
                  dir_rows[r].ihl, dir_rows[r].doff, dir_rows[r].len, fr);
      force_zero = dir_rows[r].zero;
      force_status = dir_rows[r].status;
      send_frame(fr, dir_rows[r].eth);
      force_zero = 1'b0;
      force_status = -1;
    end

    // random frames across several register settings, extremes included
    random_phase(60, 2);
    load_setting(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
    random_phase(50, 1);
    // equal tag types and equal ip types
    load_setting(16'h88A8, 16'h88A8, 16'h86DD, 16'h86DD);
    random_phase(50, 1);
    load_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    random_phase(40, 1);
    load_setting(RST_SINGLE_TAG, RST_DOUBLE_TAG, RST_IPV4_TYPE, RST_IPV6_TYPE);
    random_phase(50, 1);

    wait_drained();
    repeat (10) @(negedge clk);
    $display("covered %0d frames, %0d bytes, %0d records under %0d register settings",
             frames_sent, bytes_sent, records_seen, settings_used);
    $display("tag layouts, ipv4/ipv6, tcp/udp/icmp, short headers and a long output stall");
    if (errors == 0 && header_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("timeout with %0d records outstanding", header_q.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/ehp_pkg.sv
rtl/core/ehp_capture.sv
rtl/core/ehp_record.sv
rtl/core/ethernet_ip_l4_header_parser_core.sv
rtl/core/ehp_checker.sv
sim/testbench.sv
